// File: hdl/sfe_pkg.sv
// Shared constants and types for the stereo feedforward echo core.
package sfe_pkg;

    localparam int FRAMES_DEF      = 131072;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 17;
    localparam int GAIN_SHIFT = 15;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 16'd32768;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd22938;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd0;

    // Register index, taken from paddr[2]
    localparam logic REG_GAIN  = 1'b0;
    localparam logic REG_DELAY = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              pass;
        logic              hist_ok;
    } t_mix_ctl;

endpackage

// File: hdl/stereo_feedforward_echo_core.sv
// Stereo feedforward echo: top level with two channel lanes and output merge.
//
// Input frames arrive on the s_axis channel (left sample low, right sample
// high) and mixed frames leave on m_axis in the same packing. Each channel
// is blended with the same channel delay_frames earlier using a Q1.15 gain;
// a delay of zero passes the input through.
// Registers sit on the APB port: mix_gain at 0x0, delay_frames at 0x4.
// Change them only while no transaction is in flight.
// Each accepted frame passes the registers r_a, r_b and r_out before it
// shows as output valid. One frame is taken every cycle while the output
// is not stalled; the history RAMs are written at the accept edge and read
// in the same cycle, one port each, so they never limit rate.
// When m_axis_tready is low with a result waiting, the whole three-stage
// pipeline holds and s_axis_tready drops until the result is taken.
// Reset clears the pipeline, the registers and the ring pointer; the
// history is not swept, a fill count makes unwritten entries read as zero,
// so the block takes frames from the first cycle after reset.
// FRAMES must be a power of two.
module stereo_feedforward_echo_core #(
    parameter int FRAMES      = sfe_pkg::FRAMES_DEF,
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF,
    parameter int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [TDATA_W-1:0]         s_axis_tdata,  // left_sample, right_sample, pad
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [TDATA_W-1:0]         m_axis_tdata,  // left_out, right_out, pad
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfe_pkg::CFG_AW-1:0] paddr,
    input  logic [sfe_pkg::CFG_DW-1:0] pwdata,
    output logic [sfe_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import sfe_pkg::*;

    localparam int AW = $clog2(FRAMES);

    logic                          adv;
    logic                          accept;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    t_mix_ctl                      ctl;
    logic signed [SAMPLE_BITS-1:0] x_l;
    logic signed [SAMPLE_BITS-1:0] x_r;
    logic signed [SAMPLE_BITS-1:0] y_l;
    logic signed [SAMPLE_BITS-1:0] y_r;
    logic                          r_a_vld;
    logic                          r_b_vld;
    logic                          r_out_vld;
    logic [SAMPLE_BITS-1:0]        r_out_l;
    logic [SAMPLE_BITS-1:0]        r_out_r;

    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign x_l = s_axis_tdata[SAMPLE_BITS-1:0];
    assign x_r = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    sfe_ctrl #(
        .FRAMES (FRAMES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_accept  (accept),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr),
        .o_ctl     (ctl)
    );

    sfe_lane #(
        .FRAMES      (FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .i_clk     (i_clk),
        .i_ce      (adv),
        .i_accept  (accept),
        .i_x       (x_l),
        .i_ctl     (ctl),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .o_y       (y_l)
    );

    sfe_lane #(
        .FRAMES      (FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .i_clk     (i_clk),
        .i_ce      (adv),
        .i_accept  (accept),
        .i_x       (x_r),
        .i_ctl     (ctl),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .o_y       (y_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld   <= accept;
            r_b_vld   <= r_a_vld;
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_l <= y_l;
            r_out_r <= y_r;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TDATA_W'({r_out_r, r_out_l});

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_a_vld)
        else $error("accepted frame missing from first stage");

    a_mid_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && adv) |=> r_out_vld)
        else $error("mix stage lost a frame");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && r_b_vld) |=> r_b_vld && r_out_vld && $stable(r_out_l) && $stable(r_out_r))
        else $error("pipeline moved during output stall");

endmodule

// File: hdl/sfe_ram.sv
// Generic simple dual-port RAM with registered, read-first read port.
module sfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/sfe_ctrl.sv
// Configuration registers, ring pointer, fill count and history address generation.
module sfe_ctrl #(
    parameter int FRAMES = sfe_pkg::FRAMES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfe_pkg::CFG_AW-1:0] paddr,
    input  logic [sfe_pkg::CFG_DW-1:0] pwdata,
    output logic [sfe_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       i_accept,
    output logic [$clog2(FRAMES)-1:0]  o_wr_addr,
    output logic [$clog2(FRAMES)-1:0]  o_rd_addr,
    output sfe_pkg::t_mix_ctl          o_ctl
);
    import sfe_pkg::*;

    localparam int AW = $clog2(FRAMES);
    localparam logic [AW:0] FILL_MAX = (AW+1)'(FRAMES);

    logic [GAIN_W-1:0]  r_gain;
    logic [DELAY_W-1:0] r_delay;
    logic [AW-1:0]      r_wr_ptr;
    logic [AW:0]        r_fill;
    logic [AW:0]        n_fill;
    logic [AW-1:0]      dmod;
    logic [AW:0]        lag;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_delay <= DELAY_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_GAIN:  r_gain  <= pwdata[GAIN_W-1:0];
                REG_DELAY: r_delay <= pwdata[DELAY_W-1:0];
                default:   r_gain  <= r_gain;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GAIN:  prdata = CFG_DW'(r_gain);
            REG_DELAY: prdata = CFG_DW'(r_delay);
            default:   prdata = '0;
        endcase
    end

    assign n_fill = (r_fill == FILL_MAX) ? r_fill : r_fill + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else if (i_accept) begin
            r_wr_ptr <= r_wr_ptr + 1'b1;
            r_fill   <= n_fill;
        end
    end

    // Delay wraps modulo the ring; a wrapped zero means a full ring back
    assign dmod = AW'(r_delay);
    assign lag  = (dmod == '0) ? FILL_MAX : {1'b0, dmod};

    assign o_wr_addr     = r_wr_ptr;
    assign o_rd_addr     = r_wr_ptr - dmod;
    assign o_ctl.gain    = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
    assign o_ctl.pass    = (r_delay == '0);
    assign o_ctl.hist_ok = (lag <= r_fill);

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count beyond ring size");

    a_ptr_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_wr_ptr == AW'($past(r_wr_ptr) + 1'b1))
        else $error("write pointer did not advance on accept");

endmodule

// File: hdl/sfe_lane.sv
// One channel lane: history RAM, delayed-sample select and gain-weighted mix.
module sfe_lane #(
    parameter int FRAMES      = sfe_pkg::FRAMES_DEF,
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  sfe_pkg::t_mix_ctl             i_ctl,
    input  logic [$clog2(FRAMES)-1:0]     i_wr_addr,
    input  logic [$clog2(FRAMES)-1:0]     i_rd_addr,
    output logic signed [SAMPLE_BITS-1:0] o_y
);
    import sfe_pkg::*;

    localparam int PW = SAMPLE_BITS + GAIN_W + 1;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] ROUND_BIAS = SW'((1 << GAIN_SHIFT) - 1);

    logic signed [SAMPLE_BITS-1:0] rdata;
    logic signed [SAMPLE_BITS-1:0] r_a_x;
    t_mix_ctl                      r_a_ctl;
    logic signed [SAMPLE_BITS-1:0] d;
    logic [GAIN_W-1:0]             w_in;
    logic signed [PW-1:0]          r_b_p0;
    logic signed [PW-1:0]          r_b_p1;
    logic signed [SW-1:0]          acc;
    logic signed [SW-1:0]          q;

    sfe_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (FRAMES)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_accept),
        .i_waddr (i_wr_addr),
        .i_wdata (i_x),
        .i_re    (i_ce),
        .i_raddr (i_rd_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_x   <= i_x;
            r_a_ctl <= i_ctl;
        end
    end

    // Unwritten history reads as zero
    always_comb begin
        priority if (r_a_ctl.pass) begin
            d = r_a_x;
        end else if (r_a_ctl.hist_ok) begin
            d = rdata;
        end else begin
            d = '0;
        end
    end

    assign w_in = GAIN_ONE - r_a_ctl.gain;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_b_p0 <= PW'($signed({1'b0, w_in}) * r_a_x);
            r_b_p1 <= PW'($signed({1'b0, r_a_ctl.gain}) * d);
        end
    end

    // Truncate toward zero: bias negative sums before the arithmetic shift
    assign acc = SW'(r_b_p0) + SW'(r_b_p1);
    assign q   = (acc + (acc[SW-1] ? ROUND_BIAS : SW'(0))) >>> GAIN_SHIFT;
    assign o_y = q[SAMPLE_BITS-1:0];

endmodule

// File: sim/echo_mix_checker.sv
// Checker for the stereo echo core: predicts every mixed frame and compares it on the output.
module echo_mix_checker #(
    parameter int FRAMES = sfe_pkg::FRAMES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [31:0]                i_s_tdata,   // left_sample, right_sample
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [31:0]                i_m_tdata,   // left_out, right_out
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [sfe_pkg::CFG_AW-1:0] i_paddr,
    input  logic [sfe_pkg::CFG_DW-1:0] i_pwdata,
    input  logic [sfe_pkg::CFG_DW-1:0] i_prdata,
    input  logic                       i_pready,
    output int                         o_mismatches,
    output int                         o_pending
);

    localparam int RING_DEPTH = 2 * FRAMES;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
    } t_stereo_frame;

    logic signed [15:0]            echo_ring [RING_DEPTH];
    logic [PTR_W-1:0]              ring_ptr;
    logic [sfe_pkg::GAIN_W-1:0]    gain_reg;
    logic [sfe_pkg::DELAY_W-1:0]   delay_reg;
    t_stereo_frame                 pending_frames [$];
    int                            mismatch_count = 0;

    function automatic logic signed [15:0] blend_sample(input logic signed [15:0] x,
                                                        input logic signed [15:0] d,
                                                        input logic [sfe_pkg::GAIN_W-1:0] g);
        longint acc;
        acc = (longint'(sfe_pkg::GAIN_ONE) - longint'(g)) * longint'(x)
            + longint'(g) * longint'(d);
        // signed division truncates toward zero
        return 16'(acc / longint'(sfe_pkg::GAIN_ONE));
    endfunction

    // Mix one frame against the ring and push it into the ring.
    function automatic t_stereo_frame echo_mix(input t_stereo_frame in_frame);
        logic [sfe_pkg::GAIN_W-1:0] g;
        logic [PTR_W-1:0]           off;
        logic [PTR_W-1:0]           rd_left;
        logic [PTR_W-1:0]           rd_right;
        logic [PTR_W-1:0]           wr_right;
        logic signed [15:0]         dl;
        logic signed [15:0]         dr;
        t_stereo_frame              res;
        g = (gain_reg > sfe_pkg::GAIN_ONE) ? sfe_pkg::GAIN_ONE : gain_reg;
        if (delay_reg == '0) begin
            dl = in_frame.left;
            dr = in_frame.right;
        end else begin
            off      = PTR_W'(2 * (int'(delay_reg) % FRAMES));
            rd_left  = ring_ptr - off;
            rd_right = rd_left + 1'b1;
            dl       = echo_ring[rd_left];
            dr       = echo_ring[rd_right];
        end
        res.left  = blend_sample(in_frame.left, dl, g);
        res.right = blend_sample(in_frame.right, dr, g);
        wr_right  = ring_ptr + 1'b1;
        echo_ring[ring_ptr] = in_frame.left;
        echo_ring[wr_right] = in_frame.right;
        ring_ptr = ring_ptr + 2'd2;
        return res;
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_stereo_frame want;
        t_stereo_frame got;
        logic [31:0]   reg_value;
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH; k++)
                echo_ring[k] = '0;
            ring_ptr  = '0;
            gain_reg  = sfe_pkg::GAIN_RESET;
            delay_reg = sfe_pkg::DELAY_RESET;
            pending_frames.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_paddr[2] == sfe_pkg::REG_GAIN)
                    reg_value = {16'd0, gain_reg};
                else
                    reg_value = {15'd0, delay_reg};
                if (i_pwrite) begin
                    if (i_paddr[2] == sfe_pkg::REG_GAIN)
                        gain_reg = i_pwdata[sfe_pkg::GAIN_W-1:0];
                    else
                        delay_reg = i_pwdata[sfe_pkg::DELAY_W-1:0];
                end else if (i_prdata !== reg_value) begin
                    report_mismatch("register readback", reg_value, i_prdata);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (pending_frames.size() == 0) begin
                    report_mismatch("output transaction with nothing outstanding", '0, got);
                end else begin
                    want = pending_frames.pop_front();
                    if (got.left !== want.left)
                        report_mismatch("left_out", {16'd0, want.left}, {16'd0, got.left});
                    if (got.right !== want.right)
                        report_mismatch("right_out", {16'd0, want.right}, {16'd0, got.right});
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_frames.push_back(echo_mix(i_s_tdata));
        end
        o_mismatches = mismatch_count;
        o_pending    = pending_frames.size();
    end

endmodule

// File: sim/testbench.sv
// Top of the stereo echo testbench: clock, reset, stimulus, idling and the verdict.
module testbench;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int HOLD_CYCLES      = 80;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 50;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [31:0]                m_axis_tdata;
    logic                       psel          = 1'b0;
    logic                       penable       = 1'b0;
    logic                       pwrite        = 1'b0;
    logic [sfe_pkg::CFG_AW-1:0] paddr         = '0;
    logic [sfe_pkg::CFG_DW-1:0] pwdata        = '0;
    logic [sfe_pkg::CFG_DW-1:0] prdata;
    logic                       pready;

    int mismatches;
    int pending;
    int quiet_cycles = 0;
    int frames_sent  = 0;
    int stall_left   = 0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;
    bit tx_gaps      = 1'b1;
    bit rx_stalls    = 1'b1;

    stereo_feedforward_echo_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    echo_mix_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 3);
        else if ($urandom_range(0, 9) < 9)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input logic [15:0] left, input logic [15:0] right);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 9) < 3) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        frames_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [sfe_pkg::CFG_AW-1:0] addr,
                              input logic [sfe_pkg::CFG_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back();
        apb_access(1'b0, {sfe_pkg::REG_GAIN, 2'b00}, '0);
        apb_access(1'b0, {sfe_pkg::REG_DELAY, 2'b00}, '0);
    endtask

    // Upper bits of each write carry junk that the register must drop.
    task automatic set_mix(input logic [15:0] gain, input logic [16:0] delay);
        apb_access(1'b1, {sfe_pkg::REG_GAIN, 2'b00}, {16'($urandom), gain});
        apb_access(1'b1, {sfe_pkg::REG_DELAY, 2'b00}, {15'($urandom), delay});
        read_back();
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            stall_left = HOLD_CYCLES;
            hold_done  = 1'b1;
        end else if (stall_left == 0 && rx_stalls && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [15:0] gain;
        logic [16:0] delay;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, pass-through
        read_back();
        send_frame(16'h8000, 16'h7fff);
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'h0000, 16'hffff);
        send_frame(16'h5555, 16'haaaa);
        send_frame(16'haaaa, 16'h5555);
        drain();

        // delayed sample alone, one frame back
        set_mix(sfe_pkg::GAIN_ONE, 17'd1);
        send_frame(16'h1234, 16'hedcb);
        send_frame(16'h8000, 16'h7fff);
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'hffff, 16'h0001);
        drain();

        // gain above one saturates
        set_mix(16'hffff, 17'd2);
        send_frame(16'h0001, 16'h8000);
        send_frame(16'h7fff, 16'hffff);
        send_frame(16'h8000, 16'h0000);
        drain();

        // zero gain with the longest delay
        set_mix(16'd0, 17'h1ffff);
        send_frame(16'h8000, 16'h7fff);
        send_frame(16'h4321, 16'hbcde);
        send_frame(16'hffff, 16'h0000);
        drain();

        // half mix: odd sums truncate toward zero
        set_mix(16'd16384, 17'd1);
        send_frame(16'h8000, 16'h7fff);
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'h8000, 16'h7fff);
        send_frame(16'hffff, 16'h0001);
        send_frame(16'h0001, 16'hffff);
        drain();

        // delay reaching back to the first frame after reset
        set_mix(sfe_pkg::GAIN_RESET, 17'(frames_sent));
        send_frame(pick_sample(), pick_sample());
        send_frame(pick_sample(), pick_sample());
        send_frame(pick_sample(), pick_sample());
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       gain = sfe_pkg::GAIN_ONE;
                1:       gain = 16'd0;
                2:       gain = 16'($urandom_range(32769, 65535));
                default: gain = 16'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(0, 5))
                0:       delay = 17'd0;
                1:       delay = 17'($urandom_range(0, 131071));
                2:       delay = 17'(frames_sent - $urandom_range(0, 3));
                default: delay = 17'($urandom_range(1, 40));
            endcase
            set_mix(gain, delay);
            tx_gaps   = !(ph == 2 || ph == 5);
            rx_stalls = !(ph == 2 || ph == 5);
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
                send_frame(pick_sample(), pick_sample());
            drain();
        end

        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: stereo_feedforward_echo_core.f
hdl/sfe_pkg.sv
hdl/sfe_ram.sv
hdl/sfe_ctrl.sv
hdl/sfe_lane.sv
hdl/stereo_feedforward_echo_core.sv
sim/echo_mix_checker.sv
sim/testbench.sv
